// ----- rtl/core/amdfs_pkg.sv -----
// Shared types, codes and sizes of the adjacency matrix depth-first walker.
`default_nettype none

package amdfs_pkg;

    // Field widths fixed by the item formats.
    localparam int VERTEX_W = 4;
    localparam int STAMP_W  = 6;
    localparam int CMD_W    = 2;

    // Vertices that a 4-bit index can name, and the default matrix size.
    localparam int MAX_VERT     = 16;
    localparam int DEF_VERTICES = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

    // Event kinds.
    localparam logic EV_ENTER = 1'b0;
    localparam logic EV_LEAVE = 1'b1;

    typedef logic [VERTEX_W-1:0] t_vertex;
    typedef logic [STAMP_W-1:0]  t_stamp;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        t_vertex          src;
        t_vertex          dst;
    } t_in_item;

    typedef struct packed {
        logic    event_kind;
        t_vertex vertex;
        t_stamp  stamp;
        logic    last;
    } t_out_item;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_CLEAR   = 3'd1,
        OP_ADD     = 3'd2,
        OP_START   = 3'd3,
        OP_ENTER   = 3'd4,
        OP_FOUND   = 3'd5,
        OP_ADVANCE = 3'd6,
        OP_LEAVE   = 3'd7
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic src_ok;     // start vertex lies inside the matrix
        logic hit;        // scanned neighbour has an edge and is unvisited
        logic scan_done;  // every neighbour of the top vertex has been scanned
        logic depth_one;  // only the start vertex remains on the stack
        logic out_free;   // output register can take an event this cycle
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/core/amdfs_ctrl.sv -----
// Controller state machine of the depth-first walker.
`default_nettype none

module amdfs_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic [amdfs_pkg::CMD_W-1:0]     i_in_cmd,
    input  wire amdfs_pkg::t_dp_status           i_status,
    output      logic                            o_in_stall,
    output      amdfs_pkg::t_dp_cmd              o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ENTER = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_LEAVE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = amdfs_pkg::OP_NOP;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        amdfs_pkg::CMD_CLEAR: o_cmd.op = amdfs_pkg::OP_CLEAR;
                        amdfs_pkg::CMD_ADD:   o_cmd.op = amdfs_pkg::OP_ADD;
                        amdfs_pkg::CMD_RUN: begin
                            o_cmd.op = amdfs_pkg::OP_START;
                            if (i_status.src_ok) begin
                                n_state = ST_ENTER;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ENTER: begin
                if (i_status.out_free) begin
                    o_cmd.op = amdfs_pkg::OP_ENTER;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_LEAVE;
                end else if (i_status.hit) begin
                    o_cmd.op = amdfs_pkg::OP_FOUND;
                    n_state  = ST_ENTER;
                end else begin
                    o_cmd.op = amdfs_pkg::OP_ADVANCE;
                end
            end
            ST_LEAVE: begin
                if (i_status.out_free) begin
                    o_cmd.op = amdfs_pkg::OP_LEAVE;
                    n_state  = i_status.depth_one ? ST_IDLE : ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Events are only issued when the output register can take them.
    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == amdfs_pkg::OP_ENTER || o_cmd.op == amdfs_pkg::OP_LEAVE)
            |-> i_status.out_free)
        else $error("event issued while the output register is occupied");

    // A finished scan always leads to the leave step.
    a_scan_to_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_status.scan_done) |=> (r_state == ST_LEAVE))
        else $error("finished scan did not move to the leave step");

endmodule

`default_nettype wire

// ----- rtl/core/amdfs_datapath.sv -----
// Datapath of the depth-first walker: matrix, visited marks, stack, stamps, output.
`default_nettype none

module amdfs_datapath #(
    parameter int VERTICES = amdfs_pkg::DEF_VERTICES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire amdfs_pkg::t_in_item   i_in_data,
    input  wire amdfs_pkg::t_dp_cmd    i_cmd,
    input  wire logic                  i_out_stall,
    output      amdfs_pkg::t_dp_status o_status,
    output      logic                  o_out_valid,
    output      amdfs_pkg::t_out_item  o_out_data
);

    // Only vertices that a 4-bit index can name take part.
    localparam int NV = (VERTICES < amdfs_pkg::MAX_VERT) ? VERTICES : amdfs_pkg::MAX_VERT;
    localparam int SW = $clog2(NV);
    localparam int CW = $clog2(NV + 1);
    localparam int AW = amdfs_pkg::VERTEX_W + 1;

    logic [NV-1:0]          r_adj [NV];
    logic [NV-1:0]          r_visited;
    amdfs_pkg::t_vertex     r_stk_vtx [NV];
    logic [CW-1:0]          r_stk_nxt [NV];
    logic [CW-1:0]          r_depth;
    amdfs_pkg::t_stamp      r_stamp;
    amdfs_pkg::t_vertex     r_top;
    amdfs_pkg::t_vertex     r_cand;
    logic [CW-1:0]          r_idx;
    logic                   r_out_valid;
    amdfs_pkg::t_out_item   r_out;

    logic [CW-1:0] n_depth_dec;
    logic [CW-1:0] n_depth_inc;
    logic [CW-1:0] n_idx_inc;
    logic [SW-1:0] w_top_addr;
    logic [SW-1:0] w_prev_addr;
    logic [SW-1:0] w_push_addr;
    logic          w_add_ok;

    assign n_depth_dec = r_depth - CW'(1);
    assign n_depth_inc = r_depth + CW'(1);
    assign n_idx_inc   = r_idx + CW'(1);
    assign w_top_addr  = n_depth_dec[SW-1:0];
    assign w_prev_addr = SW'(r_depth - CW'(2));
    assign w_push_addr = r_depth[SW-1:0];

    assign w_add_ok = (AW'(i_in_data.src) < AW'(NV)) && (AW'(i_in_data.dst) < AW'(NV));

    always_comb begin
        o_status.src_ok    = (AW'(i_in_data.src) < AW'(NV));
        o_status.scan_done = (r_idx == CW'(NV));
        o_status.hit       = !o_status.scan_done
                             && r_adj[r_top[SW-1:0]][r_idx[SW-1:0]]
                             && !r_visited[r_idx[SW-1:0]];
        o_status.depth_one = (r_depth == CW'(1));
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    // Control state and the matrix, which both have defined reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NV; r++) begin
                r_adj[r] <= '0;
            end
            r_visited   <= '0;
            r_depth     <= '0;
            r_stamp     <= amdfs_pkg::STAMP_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                amdfs_pkg::OP_CLEAR: begin
                    for (int r = 0; r < NV; r++) begin
                        r_adj[r] <= '0;
                    end
                end
                amdfs_pkg::OP_ADD: begin
                    if (w_add_ok) begin
                        r_adj[i_in_data.src[SW-1:0]][i_in_data.dst[SW-1:0]] <= 1'b1;
                    end
                end
                amdfs_pkg::OP_START: begin
                    r_visited <= '0;
                    r_depth   <= '0;
                    r_stamp   <= amdfs_pkg::STAMP_W'(1);
                end
                amdfs_pkg::OP_ENTER: begin
                    r_visited[r_cand[SW-1:0]] <= 1'b1;
                    r_depth <= n_depth_inc;
                    r_stamp <= r_stamp + amdfs_pkg::STAMP_W'(1);
                end
                amdfs_pkg::OP_LEAVE: begin
                    r_depth <= n_depth_dec;
                    r_stamp <= r_stamp + amdfs_pkg::STAMP_W'(1);
                end
                default: ;
            endcase

            if (i_cmd.op == amdfs_pkg::OP_ENTER || i_cmd.op == amdfs_pkg::OP_LEAVE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stack entries, scan position and the output payload.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            amdfs_pkg::OP_START: begin
                r_cand <= i_in_data.src;
            end
            amdfs_pkg::OP_ENTER: begin
                r_stk_vtx[w_push_addr] <= r_cand;
                r_stk_nxt[w_push_addr] <= '0;
                r_top                  <= r_cand;
                r_idx                  <= '0;
                r_out.event_kind       <= amdfs_pkg::EV_ENTER;
                r_out.vertex           <= r_cand;
                r_out.stamp            <= r_stamp;
                r_out.last             <= 1'b0;
            end
            amdfs_pkg::OP_FOUND: begin
                r_stk_nxt[w_top_addr] <= n_idx_inc;
                r_cand                <= amdfs_pkg::VERTEX_W'(r_idx);
            end
            amdfs_pkg::OP_ADVANCE: begin
                r_idx <= n_idx_inc;
            end
            amdfs_pkg::OP_LEAVE: begin
                r_out.event_kind <= amdfs_pkg::EV_LEAVE;
                r_out.vertex     <= r_top;
                r_out.stamp      <= r_stamp;
                r_out.last       <= o_status.depth_one;
                r_top            <= r_stk_vtx[w_prev_addr];
                r_idx            <= r_stk_nxt[w_prev_addr];
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CW'(NV))
        else $error("stack depth exceeds the number of vertices");

    a_leave_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == amdfs_pkg::OP_LEAVE) |-> (r_depth != '0))
        else $error("leave step on an empty stack");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == amdfs_pkg::OP_LEAVE && o_status.depth_one) |=> (r_depth == '0))
        else $error("final leave did not empty the stack");

    a_stamp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.stamp != '0))
        else $error("event carries a zero stamp");

endmodule

`default_nettype wire

// ----- rtl/core/adjacency_matrix_dfs.sv -----
// Top level of the depth-first walker over a directed adjacency bit matrix.
`default_nettype none

// Channel  Direction  Valid        Stall        Payload
// input    in         i_in_valid   o_in_stall   i_in_data  (cmd, src, dst)
// output   out        o_out_valid  i_out_stall  o_out_data (event_kind, vertex, stamp, last)
//
// The neighbour scan examines one matrix bit per cycle. Reset is synchronous
// and active low; it clears the matrix, the visited marks and the stack depth
// and sets the stamp counter to one. A stall on the output holds the walk at
// its next event.

module adjacency_matrix_dfs #(
    parameter int VERTICES = amdfs_pkg::DEF_VERTICES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire amdfs_pkg::t_in_item  i_in_data,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      amdfs_pkg::t_out_item o_out_data
);

    // The controller sequences the walk; the datapath holds the matrix, stack
    // and other walk state and reports back through a small status group.
    amdfs_pkg::t_dp_cmd    w_cmd;
    amdfs_pkg::t_dp_status w_status;

    amdfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_data.cmd),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // Each event lands in the output register, so the neighbour scan carries on
    // while the previous transaction waits to be taken; the next event waits for it.
    amdfs_datapath #(
        .VERTICES (VERTICES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- tb/sv/adjacency_matrix_dfs_tb.sv -----
// Self-checking testbench for the adjacency matrix depth-first walker.

module adjacency_matrix_dfs_tb;

    // The walker is built at its default size. Every 4-bit vertex index is
    // then inside the matrix, so the out-of-range add and run cases cannot be
    // reached through the ports.
    localparam int VERTICES = amdfs_pkg::DEF_VERTICES;

    // The fourth command code has no meaning and must leave the block alone.
    localparam logic [amdfs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Run-length controls. The long receiver hold-off adds its own length on top
    // of a full walk, so the watchdog limit leaves a wide margin over both.
    localparam int ITEM_TARGET = 350;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 400;
    localparam int IDLE_LIMIT  = 5000;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_BURSTY
    } t_stall_mode;

    typedef enum int {
        GRAPH_SPARSE,
        GRAPH_DENSE,
        GRAPH_CHAIN
    } t_graph_shape;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    amdfs_pkg::t_in_item  i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    amdfs_pkg::t_out_item o_out_data;

    // Predictor state: the edge matrix as the block should hold it, and the
    // events still owed by the block, oldest first.
    logic [amdfs_pkg::MAX_VERT-1:0] adj_rows [amdfs_pkg::MAX_VERT];
    amdfs_pkg::t_out_item           pending_events [$];

    int          failures       = 0;
    int          useful_items   = 0;
    int          idle_cycles    = 0;
    bit          gaps_on        = 1'b0;
    int          burst_left     = 0;
    t_stall_mode out_stall_mode = STALL_NONE;
    int          hold_request   = 0;
    int          hold_left      = 0;
    int          phase_left     = 0;
    bit          stall_level    = 1'b0;

    adjacency_matrix_dfs #(
        .VERTICES(VERTICES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial forever #5 i_clk = ~i_clk;

    function automatic amdfs_pkg::t_in_item make_item(
        input logic [amdfs_pkg::CMD_W-1:0] cmd, input int s, input int d);
        amdfs_pkg::t_in_item item;
        item.cmd = cmd;
        item.src = amdfs_pkg::t_vertex'(s);
        item.dst = amdfs_pkg::t_vertex'(d);
        return item;
    endfunction

    function automatic void queue_event(input logic kind, input amdfs_pkg::t_vertex v,
                                        input amdfs_pkg::t_stamp s, input logic last);
        amdfs_pkg::t_out_item ev;
        ev.event_kind = kind;
        ev.vertex     = v;
        ev.stamp      = s;
        ev.last       = last;
        pending_events.push_back(ev);
    endfunction

    // Works out the event sequence of one traversal from the current matrix.
    // The visited marks and the stamp counter restart with every run, so they
    // live only for the length of the walk. The stack holds each vertex on the
    // current path together with the next neighbour index still to be scanned.
    function automatic void predict_walk(input amdfs_pkg::t_vertex start);
        logic [amdfs_pkg::MAX_VERT-1:0] seen;
        amdfs_pkg::t_vertex             frame_vtx [amdfs_pkg::MAX_VERT];
        int                             frame_next [amdfs_pkg::MAX_VERT];
        int                             depth;
        int                             found;
        int                             produced;
        amdfs_pkg::t_stamp              stamp;
        amdfs_pkg::t_vertex             top;
        if (int'(start) >= VERTICES) begin
            return;
        end
        seen = '0;
        seen[start] = 1'b1;
        stamp = 6'd1;
        queue_event(amdfs_pkg::EV_ENTER, start, stamp, 1'b0);
        stamp = stamp + 6'd1;
        produced = 1;
        frame_vtx[0] = start;
        frame_next[0] = 0;
        depth = 1;
        while (depth > 0 && produced < 2 * amdfs_pkg::MAX_VERT) begin
            top = frame_vtx[depth - 1];
            found = -1;
            for (int i = frame_next[depth - 1]; i < VERTICES && found < 0; i++) begin
                if (adj_rows[top][i] && !seen[i]) begin
                    found = i;
                end
            end
            if (found >= 0) begin
                frame_next[depth - 1] = found + 1;
                seen[found] = 1'b1;
                queue_event(amdfs_pkg::EV_ENTER, amdfs_pkg::t_vertex'(found), stamp, 1'b0);
                frame_vtx[depth] = amdfs_pkg::t_vertex'(found);
                frame_next[depth] = 0;
                depth++;
            end else begin
                depth--;
                queue_event(amdfs_pkg::EV_LEAVE, top, stamp, depth == 0);
            end
            stamp = stamp + 6'd1;
            produced++;
        end
    endfunction

    // Applies one accepted command to the predictor.
    function automatic void apply_command(input amdfs_pkg::t_in_item item);
        case (item.cmd)
            amdfs_pkg::CMD_CLEAR: begin
                foreach (adj_rows[r]) adj_rows[r] = '0;
            end
            amdfs_pkg::CMD_ADD: begin
                if (int'(item.src) < VERTICES && int'(item.dst) < VERTICES) begin
                    adj_rows[item.src][item.dst] = 1'b1;
                end
            end
            amdfs_pkg::CMD_RUN: begin
                predict_walk(item.src);
            end
            default: begin
            end
        endcase
    endfunction

    // Offers one input transaction and returns at the edge that accepts it.
    // Valid is left high afterwards so that back-to-back items keep the
    // channel busy; it is only lowered for a gap between bursts or at the end.
    task automatic send_item(input amdfs_pkg::t_in_item item);
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        apply_command(item);
        if (item.cmd != CMD_UNUSED) begin
            useful_items++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Extremes of the vertex fields, every command, self loops, repeated
    // edges, a cycle back to the start vertex and the ignored command code.
    task automatic test_directed_cases();
        gaps_on = 1'b0;
        out_stall_mode = STALL_NONE;
        // Walks over the empty matrix visit only the start vertex.
        send_item(make_item(amdfs_pkg::CMD_RUN, 0, 0));
        send_item(make_item(amdfs_pkg::CMD_RUN, 15, 9));
        send_item(make_item(CMD_UNUSED, 15, 15));
        send_item(make_item(amdfs_pkg::CMD_ADD, 0, 15));
        send_item(make_item(amdfs_pkg::CMD_ADD, 15, 0));
        send_item(make_item(amdfs_pkg::CMD_ADD, 0, 15));
        send_item(make_item(amdfs_pkg::CMD_ADD, 5, 5));
        send_item(make_item(amdfs_pkg::CMD_ADD, 15, 5));
        send_item(make_item(amdfs_pkg::CMD_ADD, 0, 1));
        send_item(make_item(amdfs_pkg::CMD_RUN, 0, 15));
        send_item(make_item(amdfs_pkg::CMD_RUN, 15, 0));
        out_stall_mode = STALL_LIGHT;
        send_item(make_item(amdfs_pkg::CMD_RUN, 5, 10));
        send_item(make_item(amdfs_pkg::CMD_ADD, 15, 15));
        send_item(make_item(amdfs_pkg::CMD_RUN, 15, 15));
        send_item(make_item(CMD_UNUSED, 0, 0));
        send_item(make_item(amdfs_pkg::CMD_RUN, 1, 0));
        // After a clear every walk is a single vertex again.
        send_item(make_item(amdfs_pkg::CMD_CLEAR, 10, 5));
        send_item(make_item(amdfs_pkg::CMD_RUN, 0, 0));
        send_item(make_item(amdfs_pkg::CMD_RUN, 15, 15));
    endtask

    // A chain through every vertex gives the deepest stack and all 32 events.
    // The receiver then holds off for a long stretch while further runs are
    // offered, so the walk stops mid-way and the input side has to stall.
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        out_stall_mode = STALL_NONE;
        send_item(make_item(amdfs_pkg::CMD_CLEAR, 0, 0));
        for (int v = 0; v < amdfs_pkg::MAX_VERT - 1; v++) begin
            send_item(make_item(amdfs_pkg::CMD_ADD, v, v + 1));
        end
        hold_request = HOLD_CYCLES;
        send_item(make_item(amdfs_pkg::CMD_RUN, 0, 0));
        send_item(make_item(amdfs_pkg::CMD_RUN, 7, 0));
        send_item(make_item(amdfs_pkg::CMD_ADD, 15, 0));
        send_item(make_item(amdfs_pkg::CMD_RUN, 15, 0));
        send_item(make_item(amdfs_pkg::CMD_RUN, 3, 0));
    endtask

    function automatic logic [amdfs_pkg::CMD_W-1:0] CMD_WIDTH_CAST(input int code);
        return code[amdfs_pkg::CMD_W-1:0];
    endfunction

    // Mostly well-formed sequences: an optional clear, a graph of some shape,
    // then a few walks over it. The remainder is raw noise over all codes.
    task automatic test_random_graphs();
        int           order [amdfs_pkg::MAX_VERT];
        int           span;
        int           j;
        int           tmp;
        t_graph_shape shape;
        while (useful_items < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            out_stall_mode = t_stall_mode'($urandom_range(0, 2));
            foreach (order[i]) order[i] = i;
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_item(make_item(amdfs_pkg::CMD_CLEAR, $urandom_range(0, 15),
                                        $urandom_range(0, 15)));
                end
                shape = t_graph_shape'($urandom_range(0, 2));
                case (shape)
                    GRAPH_SPARSE: begin
                        repeat ($urandom_range(1, 12)) begin
                            send_item(make_item(amdfs_pkg::CMD_ADD, $urandom_range(0, 15),
                                                $urandom_range(0, 15)));
                        end
                    end
                    GRAPH_DENSE: begin
                        repeat ($urandom_range(16, 40)) begin
                            send_item(make_item(amdfs_pkg::CMD_ADD, $urandom_range(0, 15),
                                                $urandom_range(0, 15)));
                        end
                    end
                    default: begin
                        // A random path through a shuffled vertex order,
                        // with a few stray edges to give branches and cycles.
                        for (int i = amdfs_pkg::MAX_VERT - 1; i > 0; i--) begin
                            j = $urandom_range(0, i);
                            tmp = order[i];
                            order[i] = order[j];
                            order[j] = tmp;
                        end
                        span = $urandom_range(3, amdfs_pkg::MAX_VERT - 1);
                        for (int i = 0; i < span; i++) begin
                            send_item(make_item(amdfs_pkg::CMD_ADD, order[i], order[i + 1]));
                        end
                        repeat ($urandom_range(0, 3)) begin
                            send_item(make_item(amdfs_pkg::CMD_ADD, $urandom_range(0, 15),
                                                $urandom_range(0, 15)));
                        end
                    end
                endcase
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1) != 0) begin
                        send_item(make_item(amdfs_pkg::CMD_RUN, order[0],
                                            $urandom_range(0, 15)));
                    end else begin
                        send_item(make_item(amdfs_pkg::CMD_RUN, $urandom_range(0, 15),
                                            $urandom_range(0, 15)));
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(make_item(CMD_WIDTH_CAST($urandom_range(0, 3)),
                                        $urandom_range(0, 15), $urandom_range(0, 15)));
                end
            end
        end
    endtask

    // Receiver: a stall pattern of its own, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (out_stall_mode)
                STALL_LIGHT: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                end
                STALL_BURSTY: begin
                    if (phase_left == 0) begin
                        stall_level = !stall_level;
                        phase_left = stall_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
                    end
                    phase_left--;
                    i_out_stall <= stall_level;
                end
                default: begin
                    i_out_stall <= 1'b0;
                end
            endcase
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Every accepted output transaction is compared with the oldest event
    // still owed by the predictor.
    always @(posedge i_clk) begin : check_events
        amdfs_pkg::t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_events.size() == 0) begin
                $error("unexpected output transaction: kind %0d vertex %0d stamp %0d last %0d",
                       o_out_data.event_kind, o_out_data.vertex, o_out_data.stamp,
                       o_out_data.last);
                failures++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", want.event_kind, o_out_data.event_kind);
                check_field("vertex", want.vertex, o_out_data.vertex);
                check_field("stamp", want.stamp, o_out_data.stamp);
                check_field("last", want.last, o_out_data.last);
            end
        end
    end

    // Watchdog: the run is abandoned once no transaction of either channel
    // has been accepted for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        foreach (adj_rows[r]) adj_rows[r] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_output_backpressure();
        test_random_graphs();

        // Drain: let every owed event arrive, then watch for strays.
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- adjacency_matrix_dfs.f -----
rtl/core/amdfs_pkg.sv
rtl/core/amdfs_ctrl.sv
rtl/core/amdfs_datapath.sv
rtl/core/adjacency_matrix_dfs.sv
tb/sv/adjacency_matrix_dfs_tb.sv
